// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AV2A_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define AV2A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/av2a_pkg.sv =====
// Shared constants and the divide-by-1023 digit step for the volts-to-ASCII block.
// Depends on nothing.
package av2a_pkg;

  localparam int unsigned MAX_PLACES_DEF = 6;
  localparam int unsigned RESULT_CAP     = 8;
  localparam int unsigned PLACES_LIMIT   = RESULT_CAP - 2;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned PLACES_W = 3;
  localparam int unsigned CHAR_W   = 6;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned REM_W    = 10;
  localparam int unsigned DIV_W    = 14;

  localparam logic [PLACES_W-1:0] PLACES_RESET = 3'd3;
  localparam logic [CHAR_W-1:0]   CHAR_ZERO    = 6'd48;
  localparam logic [CHAR_W-1:0]   CHAR_POINT   = 6'd46;
  localparam int unsigned         FULL_SCALE   = 1023;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [REM_W-1:0]   rem;
  } div_res_t;

  // x below 10*FULL_SCALE: quotient 0..9 and remainder by FULL_SCALE
  function automatic div_res_t div_1023(input logic [DIV_W-1:0] x);
    div_res_t            res;
    logic [DIGIT_W-1:0]  q;
    logic [DIV_W-1:0]    qx;
    q = '0;
    for (int k = 1; k < 10; k++) begin
      if (x >= DIV_W'(k * FULL_SCALE)) begin
        q = DIGIT_W'(k);
      end
    end
    qx = (DIV_W'(q) << 10) - DIV_W'(q);
    res.digit = q;
    res.rem   = REM_W'(x - qx);
    return res;
  endfunction

endpackage

// ===== rtl/av2a_cell.sv =====
// One long-division cell: scale the incoming remainder by ten, divide by 1023.
// Depends on av2a_pkg.
module av2a_cell import av2a_pkg::*; (
  input  logic               clk,
  input  logic [REM_W-1:0]   rem_in,
  output logic [REM_W-1:0]   rem_out,
  output logic [DIGIT_W-1:0] digit_out
);

  logic [DIV_W-1:0] prod;
  div_res_t         res_nxt;
  logic [REM_W-1:0]   rem_r;
  logic [DIGIT_W-1:0] digit_r;

  assign prod    = (DIV_W'(rem_in) << 3) + (DIV_W'(rem_in) << 1);
  assign res_nxt = div_1023(prod);

  always_ff @(posedge clk) begin
    rem_r   <= res_nxt.rem;
    digit_r <= res_nxt.digit;
  end

  assign rem_out   = rem_r;
  assign digit_out = digit_r;

endmodule

// ===== rtl/adc_volts_to_ascii_core.sv =====
// Top level: converts a 10-bit sample to volts as an ASCII string, one char per request.
// Depends on av2a_pkg and av2a_cell.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   in      | in_valid, in_stall, in_adc_sample  | sample in
//   out     | out_valid, out_stall, out_ascii_char, out_last_char | chars out
//   cfg     | cfg_wr_en, cfg_wr_data             | decimal_places write
//
// A sample yields places+2 chars, one per cycle without stalls; the output register
// and the single char position counter set that figure. The cell row computes digit k
// after acceptance, ahead of its slot. A new sample is taken once its predecessor's last
// char is loaded and no output stall holds it. Reset is synchronous, active low, and
// sets decimal_places to 3. An output stall holds the output register and the counter.
module adc_volts_to_ascii_core import av2a_pkg::*; #(
  parameter int unsigned MAX_PLACES = MAX_PLACES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_adc_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAR_W-1:0]   out_ascii_char,
  output logic                out_last_char,
  input  logic                cfg_wr_en,
  input  logic [PLACES_W-1:0] cfg_wr_data
);

  localparam int unsigned NCELL = (MAX_PLACES > PLACES_LIMIT) ? PLACES_LIMIT : MAX_PLACES;
  localparam int unsigned PW    = $clog2(NCELL + 2);

  logic [PLACES_W-1:0] dp_r;
  logic [PLACES_W-1:0] plc_r;
  logic [PLACES_W-1:0] plc;
  logic [REM_W-1:0]    seed_r;
  logic [PW-1:0]       pos_r;
  logic                busy_r;
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  logic [REM_W-1:0]    rem_chain [NCELL+1];
  logic [DIGIT_W-1:0]  digits    [NCELL];
  logic [DIGIT_W-1:0]  sel_digit;
  logic [DIV_W-1:0]    scaled;
  div_res_t            whole;
  logic                acc;
  logic                ld;
  logic [CHAR_W-1:0]   nxt_char;
  logic                nxt_last;

  assign in_stall = busy_r | (out_valid_r & out_stall);
  assign acc      = in_valid & ~in_stall;
  assign ld       = busy_r & (~out_valid_r | ~out_stall);

  assign scaled = (DIV_W'(in_adc_sample) << 2) + DIV_W'(in_adc_sample);
  assign whole  = div_1023(scaled);
  assign plc    = (dp_r > PLACES_W'(NCELL)) ? PLACES_W'(NCELL) : dp_r;

  assign rem_chain[0] = seed_r;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    av2a_cell u_cell (
      .clk       (clk),
      .rem_in    (rem_chain[k]),
      .rem_out   (rem_chain[k+1]),
      .digit_out (digits[k])
    );
  end

  always_comb begin
    sel_digit = '0;
    for (int k = 0; k < NCELL; k++) begin
      if (pos_r == PW'(k + 2)) begin
        sel_digit = digits[k];
      end
    end
  end

  always_comb begin
    if (pos_r == PW'(1)) begin
      nxt_char = CHAR_POINT;
      nxt_last = (plc_r == '0);
    end else begin
      nxt_char = CHAR_ZERO + CHAR_W'(sel_digit);
      nxt_last = ((PW + 1)'(pos_r) == (PW + 1)'(plc_r) + (PW + 1)'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r        <= PLACES_RESET;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        dp_r <= cfg_wr_data;
      end
      if (acc) begin
        busy_r      <= 1'b1;
        out_valid_r <= 1'b1;
        pos_r       <= PW'(1);
      end else if (ld) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_r + PW'(1);
        if (nxt_last) begin
          busy_r <= 1'b0;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      seed_r     <= whole.rem;
      plc_r      <= plc;
      out_char_r <= CHAR_ZERO + CHAR_W'(whole.digit);
      out_last_r <= 1'b0;
    end else if (ld) begin
      out_char_r <= nxt_char;
      out_last_r <= nxt_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last_char  = out_last_r;

endmodule

// ===== rtl/av2a_checker.sv =====
// Port-level checker for adc_volts_to_ascii_core, attached by bind.
// Depends on av2a_pkg and assert_macros.svh.
`include "assert_macros.svh"

module av2a_checker import av2a_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [SAMPLE_W-1:0] in_adc_sample,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CHAR_W-1:0]   out_ascii_char,
  input logic                out_last_char
);

  `AV2A_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_ascii_char) && $stable(out_last_char), "stalled output request changed")
  `AV2A_ASSERT_NOW(a_char_legal, clk, rst_n, out_valid, (out_ascii_char == CHAR_POINT) || ((out_ascii_char >= CHAR_ZERO) && (out_ascii_char <= CHAR_ZERO + 6'd9)), "output char is not a digit or point")
  `AV2A_ASSERT_NEXT(a_first_char, clk, rst_n, in_valid && !in_stall, out_valid && !out_last_char && (out_ascii_char >= CHAR_ZERO) && (out_ascii_char <= CHAR_ZERO + 6'd5), "first char is not an integer digit 0 to 5")
  `AV2A_ASSERT_NOW(a_busy_stall, clk, rst_n, out_valid && !out_last_char, in_stall, "input taken while a reading is still in flight")
  `AV2A_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_adc_sample), "stalled input request changed")

endmodule

bind adc_volts_to_ascii_core av2a_checker u_av2a_checker (.*);
